@@ hdl/psrl_pkg.sv @@
// ----------------------------------------------------------------------------
// Per-source packet rate limiter: shared package
// Types, constants and the address hash used by the limiter and its channels.
// ----------------------------------------------------------------------------
package psrl_pkg;

   localparam int ADDR_W        = 32;
   localparam int TIME_W        = 32;
   localparam int LIMIT_W       = 19;
   localparam int PAUSE_W       = 16;
   localparam int COUNT_W       = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int PROBES        = 5;
   localparam int PROBE_W       = 3;
   localparam int SLICE_SECONDS = 10;
   localparam int RATE_SCALE    = 60;
   localparam int RECIP_W       = 33;
   localparam int RECIP_SHIFT_W = 4;

   localparam logic [31:0]        HASH_SEED     = 32'hABC3D20F;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [LIMIT_W-1:0] RATE_MAX      = 19'd393210;
   localparam logic [LIMIT_W-1:0] HALF_DROP_RST = 19'd50;
   localparam logic [LIMIT_W-1:0] FULL_DROP_RST = 19'd50;
   localparam logic [PAUSE_W-1:0] PAUSE_RST     = 16'd20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HALF_DROP    = 2'd0,
      CSR_FULL_DROP    = 2'd1,
      CSR_REPORT_PAUSE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] source_address;
      logic [TIME_W-1:0] now_seconds;
   } req_payload_type;

   typedef struct packed {
      logic               drop;
      logic [LIMIT_W-1:0] rate_per_minute;
      logic               report;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [LIMIT_W-1:0]     data;
   } csr_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [TIME_W-1:0] last_use;
      logic [TIME_W-1:0] last_report;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0]  stamp;
      logic [COUNT_W-1:0] count;
   } slice_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Shift-xor hash over the sign-extended address octets, first octet first.
   function automatic logic [31:0] hash_address(input logic [ADDR_W-1:0] addr);
      logic [31:0] h;
      logic [31:0] oct;
      h = HASH_SEED;
      for (int k = 3; k >= 0; k--) begin
         oct = {{24{addr[8*k+7]}}, addr[8*k +: 8]};
         h   = (h << 5) ^ 32'($signed(h) >>> 23) ^ oct;
      end
      return h ^ 32'($signed(h) >>> 16);
   endfunction

   // Rounded-up reciprocal of a constant divisor, scaled by 2^(32 + ceil(log2 d)), which
   // divides any 32-bit value exactly. It is only ever evaluated for constants.
   function automatic logic [RECIP_W-1:0] recip_of(input int d);
      logic [63:0] num;
      num = (64'd1 << (32 + $clog2(d))) + 64'(d) - 64'd1;
      return RECIP_W'(num / 64'(d));
   endfunction

endpackage

@@ hdl/psrl_if.sv @@
// ----------------------------------------------------------------------------
// Per-source packet rate limiter: channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface psrl_req_if;
   logic                      valid;
   logic                      ready;
   psrl_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface psrl_rsp_if;
   logic                      valid;
   logic                      ready;
   psrl_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface psrl_csr_if;
   logic                      valid;
   logic                      ready;
   psrl_pkg::csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/psrl_div.sv @@
// ----------------------------------------------------------------------------
// Per-source packet rate limiter: constant divider
// Divides by a constant through its reciprocal: first the quotient by a
// multiply and shift, then the remainder by a multiply-subtract.
// ----------------------------------------------------------------------------
module psrl_div #(
   parameter int DIVISOR_W = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         dividend,
   input  logic [DIVISOR_W-1:0]                divisor,
   input  logic [psrl_pkg::RECIP_W-1:0]        recip,
   input  logic [psrl_pkg::RECIP_SHIFT_W-1:0]  shift,
   output psrl_pkg::div_status_type            status,
   output logic [31:0]                         quotient,
   output logic [DIVISOR_W-1:0]                remainder
);
   import psrl_pkg::*;

   logic                     run_ff, run_in;
   logic                     step_ff, step_in;
   logic                     done_ff, done_in;
   logic [31:0]              dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]     dvs_ff, dvs_in;
   logic [RECIP_W-1:0]       rcp_ff, rcp_in;
   logic [RECIP_SHIFT_W-1:0] sft_ff, sft_in;
   logic [31:0]              quo_ff, quo_in;
   logic [DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [64:0]              prod;
   logic [64:0]              prod_sh;
   logic [31:0]              back;

   assign prod    = 65'(dvd_ff) * 65'(rcp_ff);
   assign prod_sh = prod >> (7'd32 + 7'(sft_ff));
   assign back    = dvd_ff - quo_ff * 32'(dvs_ff);

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rcp_in  = rcp_ff;
      sft_in  = sft_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = 1'b0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rcp_in  = recip;
         sft_in  = shift;
      end else if (run_ff) begin
         if (!step_ff) begin
            quo_in  = prod_sh[31:0];
            step_in = 1'b1;
         end else begin
            rem_in  = back[DIVISOR_W-1:0];
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rcp_ff <= rcp_in;
      sft_ff <= sft_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

@@ hdl/per_source_packet_rate_limiter_top.sv @@
// ----------------------------------------------------------------------------
// Per-source packet rate limiter: top level
// Hashes the source address into a table of per-source entries, keeps a
// sliding window of per-slice packet counts and decides drop and report.
//
//   channel   port    direction  beat carries
//   request   req_if  in         source_address, now_seconds
//   response  rsp_if  out        drop, rate_per_minute, report
//   register  csr_if  in         index, data
//
// Between accepting a request and raising its response the limiter runs four
// constant divisions (hash, tick, time slice, rate), reads and weighs one to
// PROBES table entries, clears the SLICES slice words of a claimed slot, and
// updates one slice word and then sums all of them.
// After reset a clearing pass writes every slice word and table entry before the
// first request is taken. A finished response waits in its output register
// while the next request is accepted; only the final write-back waits on it.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter_top #(
   parameter int TABLE_ENTRIES = 256,
   parameter int SLICES        = 24
) (
   input logic       clock,
   input logic       reset,
   psrl_req_if.sink  req_if,
   psrl_rsp_if.source rsp_if,
   psrl_csr_if.sink  csr_if
);
   import psrl_pkg::*;

   localparam int IW         = $clog2(TABLE_ENTRIES);
   localparam int SIW        = $clog2(SLICES);
   localparam int CW         = $clog2(SLICES + 1);
   localparam int DEPTH      = TABLE_ENTRIES * SLICES;
   localparam int SAW        = $clog2(DEPTH);
   localparam int SUMW       = COUNT_W + $clog2(SLICES);
   localparam int WINDOW_DIV = SLICES * SLICE_SECONDS;
   localparam int MAXDIV     = (TABLE_ENTRIES > WINDOW_DIV) ? TABLE_ENTRIES : WINDOW_DIV;
   localparam int DIV_W      = $clog2(MAXDIV + 1);
   localparam longint unsigned WRAP_REM = (64'd1 << 32) % TABLE_ENTRIES;

   localparam logic [RECIP_W-1:0]       TBL_RECIP = recip_of(TABLE_ENTRIES);
   localparam logic [RECIP_W-1:0]       SEC_RECIP = recip_of(SLICE_SECONDS);
   localparam logic [RECIP_W-1:0]       SLC_RECIP = recip_of(SLICES);
   localparam logic [RECIP_W-1:0]       WIN_RECIP = recip_of(WINDOW_DIV);
   localparam logic [RECIP_SHIFT_W-1:0] TBL_SHIFT = RECIP_SHIFT_W'($clog2(TABLE_ENTRIES));
   localparam logic [RECIP_SHIFT_W-1:0] SEC_SHIFT = RECIP_SHIFT_W'($clog2(SLICE_SECONDS));
   localparam logic [RECIP_SHIFT_W-1:0] SLC_SHIFT = RECIP_SHIFT_W'($clog2(SLICES));
   localparam logic [RECIP_SHIFT_W-1:0] WIN_SHIFT = RECIP_SHIFT_W'($clog2(WINDOW_DIV));

   typedef enum logic [12:0] {
      ST_CLEAR = 13'b0000000000001,
      ST_IDLE  = 13'b0000000000010,
      ST_HMOD  = 13'b0000000000100,
      ST_TDIV  = 13'b0000000001000,
      ST_TMOD  = 13'b0000000010000,
      ST_PRD   = 13'b0000000100000,
      ST_PEV   = 13'b0000001000000,
      ST_CLAIM = 13'b0000010000000,
      ST_SRD   = 13'b0000100000000,
      ST_SWR   = 13'b0001000000000,
      ST_SUM   = 13'b0010000000000,
      ST_RDIV  = 13'b0100000000000,
      ST_FIN   = 13'b1000000000000
   } state_type;

   entry_type entry_mem [TABLE_ENTRIES];
   slice_type slice_mem [DEPTH];

   state_type          state_ff, state_in;
   logic [SAW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [31:0]        hash_ff, hash_in;
   logic [IW-1:0]      hmod_ff, hmod_in;
   logic [TIME_W-1:0]  tick_ff, tick_in;
   logic [SIW-1:0]     tslice_ff, tslice_in;
   logic [PROBE_W-1:0] probe_ff, probe_in;
   logic [IW-1:0]      cur_slot_ff, cur_slot_in;
   logic [IW-1:0]      best_slot_ff, best_slot_in;
   logic [TIME_W-1:0]  best_use_ff, best_use_in;
   logic [TIME_W-1:0]  best_rep_ff, best_rep_in;
   logic               found_ff, found_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [SUMW-1:0]    sum_ff, sum_in;
   logic [LIMIT_W-1:0] rate_ff, rate_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;
   logic [LIMIT_W-1:0] half_ff, half_in;
   logic [LIMIT_W-1:0] full_ff, full_in;
   logic [PAUSE_W-1:0] pause_ff, pause_in;

   entry_type          ent_rd_ff;
   slice_type          sl_rd_ff;
   logic               ent_we;
   logic [IW-1:0]      ent_wa;
   entry_type          ent_wd;
   logic [IW-1:0]      ent_ra;
   logic               sl_we;
   logic [SAW-1:0]     sl_wa;
   slice_type          sl_wd;
   logic [SAW-1:0]     sl_ra;

   logic                     div_start;
   logic [31:0]              div_dividend;
   logic [DIV_W-1:0]         div_divisor;
   logic [RECIP_W-1:0]       div_recip;
   logic [RECIP_SHIFT_W-1:0] div_shift;
   div_status_type           div_status;
   logic [31:0]              div_quotient;
   logic [DIV_W-1:0]         div_remainder;

   logic               wrap;
   logic [IW:0]        slot_sum;
   logic [IW:0]        slot_red;
   logic [IW:0]        slot_adj;
   logic [IW-1:0]      probe_slot;
   logic [SAW-1:0]     base;
   logic [TIME_W-1:0]  lower;
   logic               in_window;
   logic [SUMW-1:0]    sum_add;
   logic [COUNT_W-1:0] upd_count;
   logic               exc_full;
   logic               exc_half;
   logic [TIME_W-1:0]  last_rep;
   logic               report;

   psrl_div #(
      .DIVISOR_W (DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .recip     (div_recip),
      .shift     (div_shift),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Probe slot (hash + probe) mod 2^32 mod TABLE_ENTRIES, from hash mod TABLE_ENTRIES.
   always_comb begin
      wrap     = ({1'b0, hash_ff} + 33'(probe_ff)) >= 33'h100000000;
      slot_sum = (IW+1)'(hmod_ff) + (IW+1)'(probe_ff);
      slot_red = (slot_sum >= (IW+1)'(TABLE_ENTRIES)) ?
                 slot_sum - (IW+1)'(TABLE_ENTRIES) : slot_sum;
      if (!wrap) begin
         slot_adj = slot_red;
      end else if (slot_red >= (IW+1)'(WRAP_REM)) begin
         slot_adj = slot_red - (IW+1)'(WRAP_REM);
      end else begin
         slot_adj = slot_red + (IW+1)'(TABLE_ENTRIES) - (IW+1)'(WRAP_REM);
      end
      probe_slot = slot_adj[IW-1:0];
   end

   assign base      = SAW'(best_slot_ff) * SAW'(SLICES);
   assign lower     = (tick_ff >= TIME_W'(SLICES)) ? tick_ff - TIME_W'(SLICES) : '0;
   assign in_window = (sl_rd_ff.stamp <= tick_ff) && (sl_rd_ff.stamp >= lower);
   assign sum_add   = (cnt_ff != '0 && in_window) ?
                      sum_ff + SUMW'(sl_rd_ff.count) : sum_ff;
   assign exc_full  = rate_ff > full_ff;
   assign exc_half  = rate_ff > half_ff;
   assign last_rep  = found_ff ? best_rep_ff : '0;
   assign report    = (exc_full || exc_half) && ((now_ff - last_rep) > TIME_W'(pause_ff));

   always_comb begin
      upd_count = (sl_rd_ff.stamp != tick_ff) ? '0 : sl_rd_ff.count;
      if (upd_count != COUNT_MAX) begin
         upd_count = upd_count + 16'd1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      addr_in      = addr_ff;
      now_in       = now_ff;
      hash_in      = hash_ff;
      hmod_in      = hmod_ff;
      tick_in      = tick_ff;
      tslice_in    = tslice_ff;
      probe_in     = probe_ff;
      cur_slot_in  = cur_slot_ff;
      best_slot_in = best_slot_ff;
      best_use_in  = best_use_ff;
      best_rep_in  = best_rep_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      rate_in      = rate_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      half_in      = half_ff;
      full_in      = full_ff;
      pause_in     = pause_ff;
      ent_we       = 1'b0;
      ent_wa       = best_slot_ff;
      ent_wd       = '0;
      ent_ra       = probe_slot;
      sl_we        = 1'b0;
      sl_wa        = '0;
      sl_wd        = '0;
      sl_ra        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      div_recip    = '0;
      div_shift    = '0;

      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.payload.index))
            CSR_HALF_DROP:    half_in  = csr_if.payload.data;
            CSR_FULL_DROP:    full_in  = csr_if.payload.data;
            CSR_REPORT_PAUSE: pause_in = csr_if.payload.data[PAUSE_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ent_we = clr_cnt_ff < SAW'(TABLE_ENTRIES);
            ent_wa = clr_cnt_ff[IW-1:0];
            sl_we  = 1'b1;
            sl_wa  = clr_cnt_ff;
            if (clr_cnt_ff == SAW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + SAW'(1);
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               addr_in      = req_if.payload.source_address;
               now_in       = req_if.payload.now_seconds;
               hash_in      = hash_address(req_if.payload.source_address);
               div_start    = 1'b1;
               div_dividend = hash_in;
               div_divisor  = DIV_W'(TABLE_ENTRIES);
               div_recip    = TBL_RECIP;
               div_shift    = TBL_SHIFT;
               state_in     = ST_HMOD;
            end
         end
         ST_HMOD: begin
            if (div_status.done) begin
               hmod_in      = div_remainder[IW-1:0];
               div_start    = 1'b1;
               div_dividend = now_ff;
               div_divisor  = DIV_W'(SLICE_SECONDS);
               div_recip    = SEC_RECIP;
               div_shift    = SEC_SHIFT;
               state_in     = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (div_status.done) begin
               tick_in      = div_quotient;
               div_start    = 1'b1;
               div_dividend = div_quotient;
               div_divisor  = DIV_W'(SLICES);
               div_recip    = SLC_RECIP;
               div_shift    = SLC_SHIFT;
               state_in     = ST_TMOD;
            end
         end
         ST_TMOD: begin
            if (div_status.done) begin
               tslice_in = div_remainder[SIW-1:0];
               probe_in  = '0;
               state_in  = ST_PRD;
            end
         end
         ST_PRD: begin
            cur_slot_in = probe_slot;
            state_in    = ST_PEV;
         end
         ST_PEV: begin
            if (ent_rd_ff.address == addr_ff) begin
               best_slot_in = cur_slot_ff;
               best_rep_in  = ent_rd_ff.last_report;
               found_in     = 1'b1;
               state_in     = ST_SRD;
            end else begin
               if (probe_ff == '0 || ent_rd_ff.last_use == '0 ||
                   ent_rd_ff.last_use < best_use_ff) begin
                  best_slot_in = cur_slot_ff;
                  best_use_in  = ent_rd_ff.last_use;
               end
               if (probe_ff == PROBE_W'(PROBES - 1)) begin
                  found_in = 1'b0;
                  cnt_in   = '0;
                  state_in = ST_CLAIM;
               end else begin
                  probe_in = probe_ff + PROBE_W'(1);
                  state_in = ST_PRD;
               end
            end
         end
         ST_CLAIM: begin
            sl_we = 1'b1;
            sl_wa = base + SAW'(cnt_ff[SIW-1:0]);
            if (cnt_ff == CW'(SLICES - 1)) begin
               state_in = ST_SRD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_SRD: begin
            sl_ra    = base + SAW'(tslice_ff);
            state_in = ST_SWR;
         end
         ST_SWR: begin
            sl_we       = 1'b1;
            sl_wa       = base + SAW'(tslice_ff);
            sl_wd.stamp = tick_ff;
            sl_wd.count = upd_count;
            cnt_in      = '0;
            sum_in      = '0;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            sl_ra  = base + SAW'(cnt_ff[SIW-1:0]);
            sum_in = sum_add;
            if (cnt_ff == CW'(SLICES)) begin
               div_start    = 1'b1;
               div_dividend = 32'(sum_add) * 32'(RATE_SCALE);
               div_divisor  = DIV_W'(WINDOW_DIV);
               div_recip    = WIN_RECIP;
               div_shift    = WIN_SHIFT;
               state_in     = ST_RDIV;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_RDIV: begin
            if (div_status.done) begin
               rate_in  = div_quotient[LIMIT_W-1:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               ent_we             = 1'b1;
               ent_wa             = best_slot_ff;
               ent_wd.address     = addr_ff;
               ent_wd.last_use    = now_ff;
               ent_wd.last_report = report ? now_ff : last_rep;
               rsp_valid_in                = 1'b1;
               rsp_data_in.drop            = exc_full || (exc_half && sum_ff[0]);
               rsp_data_in.rate_per_minute = rate_ff;
               rsp_data_in.report          = report;
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         half_ff      <= HALF_DROP_RST;
         full_ff      <= FULL_DROP_RST;
         pause_ff     <= PAUSE_RST;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
         full_ff      <= full_in;
         pause_ff     <= pause_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      now_ff       <= now_in;
      hash_ff      <= hash_in;
      hmod_ff      <= hmod_in;
      tick_ff      <= tick_in;
      tslice_ff    <= tslice_in;
      probe_ff     <= probe_in;
      cur_slot_ff  <= cur_slot_in;
      best_slot_ff <= best_slot_in;
      best_use_ff  <= best_use_in;
      best_rep_ff  <= best_rep_in;
      found_ff     <= found_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      rate_ff      <= rate_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_wa] <= ent_wd;
      end
      ent_rd_ff <= entry_mem[ent_ra];
   end

   always_ff @(posedge clock) begin
      if (sl_we) begin
         slice_mem[sl_wa] <= sl_wd;
      end
      sl_rd_ff <= slice_mem[sl_ra];
   end

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign csr_if.ready   = 1'b1;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff == ST_HMOD && div_status.busy)
      else $error("accepted beat did not start the hash reduction");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && (!rsp_valid_ff || rsp_if.ready) |=> rsp_valid_ff)
      else $error("finished request did not raise a response beat");

   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> rate_ff <= RATE_MAX)
      else $error("rate outside its range");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-source packet rate limiter: testbench
// Sends address and time beats through the limiter under several register
// settings. A scoreboard keeps its own copy of the source table and slice
// counters, predicts drop, rate and report for every request, and compares
// each response with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import psrl_pkg::*;

   localparam int ENTRIES    = 256;
   localparam int SLICE_CNT  = 24;
   localparam int N_RANDOM   = 800;
   localparam int N_PHASES   = 5;
   localparam int SETTLE     = 250;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   class limiter_scoreboard;
      logic [31:0] ent_addr [ENTRIES];
      logic [31:0] ent_used [ENTRIES];
      logic [31:0] ent_rep  [ENTRIES];
      logic [31:0] stamp    [ENTRIES*SLICE_CNT];
      logic [15:0] count    [ENTRIES*SLICE_CNT];
      logic [LIMIT_W-1:0] half_lim = HALF_DROP_RST;
      logic [LIMIT_W-1:0] full_lim = FULL_DROP_RST;
      logic [PAUSE_W-1:0] pause    = PAUSE_RST;
      rsp_payload_type pending [$];
      int errors  = 0;
      int checked = 0;
      int drops   = 0;
      int reports = 0;

      function new();
         foreach (ent_addr[i]) begin
            ent_addr[i] = '0; ent_used[i] = '0; ent_rep[i] = '0;
         end
         foreach (stamp[i]) begin
            stamp[i] = '0; count[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] val);
         case (idx)
            CSR_HALF_DROP:    half_lim = val;
            CSR_FULL_DROP:    full_lim = val;
            CSR_REPORT_PAUSE: pause = val[PAUSE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] slot_hash(logic [31:0] a);
         logic signed [31:0] h;
         logic signed [31:0] oct;
         h = 32'hABC3D20F;
         for (int k = 3; k >= 0; k--) begin
            oct = {{24{a[8*k+7]}}, a[8*k +: 8]};
            h = (h << 5) ^ (h >>> 23) ^ oct;
         end
         return h ^ (h >>> 16);
      endfunction

      function void note_request(req_payload_type rq);
         logic [31:0] h, tick, lower, sum, slot;
         int best, base, s;
         bit hit;
         rsp_payload_type r;
         logic [63:0] rate;
         bit over;
         h = slot_hash(rq.source_address);
         best = 0;
         hit = 0;
         for (int i = 0; i < PROBES; i++) begin
            slot = (h + i) % ENTRIES;
            if (ent_addr[slot] == rq.source_address) begin
               best = slot; hit = 1; break;
            end
            if (i == 0 || ent_used[slot] == 0 || ent_used[slot] < ent_used[best])
               best = slot;
         end
         base = best * SLICE_CNT;
         if (!hit) begin
            ent_addr[best] = rq.source_address;
            for (int j = 0; j < SLICE_CNT; j++) begin
               stamp[base+j] = '0; count[base+j] = '0;
            end
            ent_rep[best] = '0;
         end
         ent_used[best] = rq.now_seconds;
         tick = rq.now_seconds / 10;
         s = base + tick % SLICE_CNT;
         if (stamp[s] != tick) begin
            stamp[s] = tick; count[s] = '0;
         end
         if (count[s] != 16'hFFFF) count[s]++;
         lower = (tick >= SLICE_CNT) ? tick - SLICE_CNT : 0;
         sum = 0;
         for (int j = 0; j < SLICE_CNT; j++)
            if (stamp[base+j] <= tick && stamp[base+j] >= lower) sum += count[base+j];
         rate = 64'(sum) * 60 / (SLICE_CNT * 10);
         over = rate > half_lim || rate > full_lim;
         r.drop = rate > full_lim || (rate > half_lim && sum[0]);
         r.rate_per_minute = rate[LIMIT_W-1:0];
         r.report = 0;
         if (over && (rq.now_seconds - ent_rep[best]) > pause) begin
            r.report = 1;
            ent_rep[best] = rq.now_seconds;
         end
         pending.push_back(r);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("response beat with nothing expected: %p", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         drops += got.drop;
         reports += got.report;
         if (got.drop !== want.drop || got.rate_per_minute !== want.rate_per_minute ||
             got.report !== want.report) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected drop %0d rate %0d report %0d, got %0d %0d %0d",
                        want.drop, want.rate_per_minute, want.report,
                        got.drop, got.rate_per_minute, got.report);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   cycles = 0;
   bit   calm = 0;
   limiter_scoreboard sb = new();

   psrl_req_if req_if();
   psrl_rsp_if rsp_if();
   psrl_csr_if csr_if();

   per_source_packet_rate_limiter_top u_dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
      if (!reset && req_if.valid && req_if.ready) sb.note_request(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
   end

   function int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 65) return 0;
      if (p < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   initial begin
      rsp_if.ready <= 0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= 1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (pick_gap() > 0) begin
            rsp_if.ready <= 0;
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   task automatic send_packet(logic [31:0] addr, logic [31:0] secs);
      int gap;
      req_if.valid <= 1;
      req_if.payload <= '{source_address: addr, now_seconds: secs};
      do @(posedge clock); while (!req_if.ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      csr_if.valid <= 1;
      csr_if.payload <= '{index: idx, data: val};
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, val);
      csr_if.valid <= 0;
   endtask

   initial begin
      logic [31:0] pool [4];
      logic [31:0] t;
      int per_phase;
      req_if.valid <= 0;
      req_if.payload <= '0;
      csr_if.valid <= 0;
      csr_if.payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 0;

      send_packet(32'h0, 32'h0);
      send_packet(32'h0, 32'h0);
      send_packet(32'hFFFFFFFF, 32'hFFFFFFFF);
      send_packet(32'h80808080, 32'd5);
      send_packet(32'h7F7F7F7F, 32'd239);
      send_packet(32'hFFFFFFFF, 32'd100);
      for (int i = 0; i < 14; i++) send_packet(32'hC0A80001, 32'd3000 + i / 4);
      drain();
      write_csr(CSR_HALF_DROP, 19'd0);
      write_csr(CSR_FULL_DROP, 19'd1);
      write_csr(CSR_REPORT_PAUSE, 19'd0);
      write_csr(CSR_UNUSED, 19'd7);
      for (int i = 0; i < 5; i++) send_packet(32'hC0A80001, 32'd3010 - i);
      drain();

      per_phase = N_RANDOM / N_PHASES;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_HALF_DROP, 19'd0);
               write_csr(CSR_FULL_DROP, 19'd0);
               write_csr(CSR_REPORT_PAUSE, 19'd0);
            end
            1: begin
               write_csr(CSR_HALF_DROP, 19'h7FFFF);
               write_csr(CSR_FULL_DROP, 19'h7FFFF);
               write_csr(CSR_REPORT_PAUSE, 19'hFFFF);
            end
            2: begin
               write_csr(CSR_HALF_DROP, 19'd3);
               write_csr(CSR_FULL_DROP, 19'd8);
               write_csr(CSR_REPORT_PAUSE, 19'($urandom_range(0, 40)));
            end
            3: begin
               write_csr(CSR_HALF_DROP, 19'($urandom_range(0, 20)));
               write_csr(CSR_FULL_DROP, 19'($urandom_range(0, 20)));
               write_csr(CSR_REPORT_PAUSE, 19'($urandom_range(0, 255)));
            end
            default: begin
               write_csr(CSR_HALF_DROP, 19'd8);
               write_csr(CSR_FULL_DROP, 19'd3);
               write_csr(CSR_REPORT_PAUSE, 19'd5);
            end
         endcase
         foreach (pool[i]) pool[i] = $urandom;
         t = (ph == 0) ? 32'd0 : $urandom;
         calm = (ph == 2);
         for (int n = 0; n < per_phase; n++) begin
            if (n == per_phase / 2) begin
               req_if.valid <= 0;
               @(posedge clock);
               while (sb.pending.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 99) < 8) begin
               send_packet($urandom, $urandom);
            end else begin
               if ($urandom_range(0, 99) < 25) t = t + $urandom_range(1, 3);
               if ($urandom_range(0, 99) < 2) t = t + $urandom_range(50, 300);
               send_packet(pool[$urandom_range(0, 3)], t);
            end
         end
         calm = 0;
         drain();
      end

      sb.errors += sb.pending.size();
      $display("checked %0d responses over %0d register settings", sb.checked, N_PHASES + 2);
      $display("dropped %0d, reported %0d", sb.drops, sb.reports);
      if (sb.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

@@ sim.f @@
hdl/psrl_pkg.sv
hdl/psrl_if.sv
hdl/psrl_div.sv
hdl/per_source_packet_rate_limiter_top.sv
verif/tb.sv
